FILE: rtl/lsim_pkg.sv
// ----------------------------------------------------------------------------
// lsim_pkg: shared types, constants and term tables for link similarity scoring
// Holds the graph geometry, operation and status codes, and the build-time
// reciprocal tables used by the score accumulator.
// ----------------------------------------------------------------------------
package lsim_pkg;

  // Graph geometry
  localparam int NODE_COUNT    = 256;
  localparam int NODE_W        = 8;
  localparam int WORD_W        = 64;
  localparam int BIT_W         = 6;                       // bit inside a row word
  localparam int WSEL_W        = NODE_W - BIT_W;          // word inside a row
  localparam int ROW_WORDS     = (NODE_COUNT + WORD_W - 1) / WORD_W;
  localparam int ADJ_DEPTH     = NODE_COUNT * ROW_WORDS;
  localparam int ADJ_AW        = NODE_W + WSEL_W;
  localparam int DEG_W         = 9;
  localparam int CNT_W         = 9;
  localparam int SCORE_W       = 32;
  localparam int FRACTION_BITS = 16;
  localparam logic [63:0] LN2_Q22 = 64'd2907270;
  localparam logic [63:0] SAT64   = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SCORE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_ABSENT    = 2'd2,
    ST_SAME_NODE = 2'd3
  } status_t;

  // Control from the sequencer to the accumulator
  typedef struct packed {
    logic clear;       // start a new score
    logic deg_valid;   // degree read data is valid this cycle
  } acc_ctrl_t;

  typedef logic [SCORE_W-1:0] term_tab_t [0:NODE_COUNT];

  // Unsigned 64-bit quotient by shift and subtract (elaboration only)
  function automatic logic [63:0] div_u64(input logic [63:0] num,
                                          input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // log2(d) with 28 fractional bits, d >= 1 (elaboration only)
  function automatic logic [63:0] log2_q28(input logic [63:0] d);
    logic [63:0] x;
    logic [63:0] res;
    int          k;
    k = 0;
    for (int i = 0; i < 63; i++) begin
      if ((d >> (i + 1)) != 64'd0) k = i + 1;
    end
    x   = (d << 30) >> k;
    res = 64'(k) << 28;
    for (int i = 0; i < 28; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        res[27-i] = 1'b1;
      end
    end
    return res;
  endfunction

  // Resource-allocation term: rounded 2^F / d
  function automatic term_tab_t ra_table();
    term_tab_t   tab;
    logic [63:0] r;
    for (int d = 0; d <= NODE_COUNT; d++) begin
      if (d == 0) begin
        tab[d] = '0;
      end else begin
        r = div_u64((64'd1 << FRACTION_BITS) + (64'(d) >> 1), 64'(d));
        if (r > SAT64) r = SAT64;
        tab[d] = r[SCORE_W-1:0];
      end
    end
    return tab;
  endfunction

  // Adamic-Adar term: rounded 2^F / ln(d), degree one saturates
  function automatic term_tab_t aa_table();
    term_tab_t   tab;
    logic [63:0] big_l;
    logic [63:0] t;
    for (int d = 0; d <= NODE_COUNT; d++) begin
      if (d == 0) begin
        tab[d] = '0;
      end else if (d == 1) begin
        tab[d] = '1;
      end else begin
        big_l = (log2_q28(64'(d)) * LN2_Q22) >> 18;
        if (big_l == 64'd0) begin
          t = SAT64;
        end else begin
          t = div_u64((64'd1 << (FRACTION_BITS + 32)) + (big_l >> 1), big_l);
          if (t > SAT64) t = SAT64;
        end
        tab[d] = t[SCORE_W-1:0];
      end
    end
    return tab;
  endfunction

  localparam term_tab_t RA_TAB = ra_table();
  localparam term_tab_t AA_TAB = aa_table();

endpackage

FILE: rtl/lsim_accum.sv
// ----------------------------------------------------------------------------
// lsim_accum: score accumulator
// Looks up the per-degree terms of each common neighbor and keeps the
// saturating count, resource-allocation sum and Adamic-Adar sum.
// ----------------------------------------------------------------------------
module lsim_accum import lsim_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  acc_ctrl_t          ctrl,
  input  logic [DEG_W-1:0]   deg,
  output logic [CNT_W-1:0]   cnt,
  output logic [SCORE_W-1:0] ra_sum,
  output logic [SCORE_W-1:0] aa_sum
);

  logic [DEG_W-1:0]   deg_cap;
  logic               term_vld_r;
  logic [SCORE_W-1:0] ra_term_r;
  logic [SCORE_W-1:0] aa_term_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SCORE_W-1:0] ra_sum_r;
  logic [SCORE_W-1:0] aa_sum_r;
  logic [SCORE_W:0]   ra_add;
  logic [SCORE_W:0]   aa_add;

  // Clamp degree to the table range
  assign deg_cap = (deg > DEG_W'(NODE_COUNT)) ? DEG_W'(NODE_COUNT) : deg;

  assign ra_add = {1'b0, ra_sum_r} + {1'b0, ra_term_r};
  assign aa_add = {1'b0, aa_sum_r} + {1'b0, aa_term_r};

  // Register the table terms, then accumulate with saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_vld_r <= 1'b0;
      cnt_r      <= '0;
      ra_sum_r   <= '0;
      aa_sum_r   <= '0;
    end else if (ctrl.clear) begin
      term_vld_r <= 1'b0;
      cnt_r      <= '0;
      ra_sum_r   <= '0;
      aa_sum_r   <= '0;
    end else begin
      term_vld_r <= ctrl.deg_valid;
      if (term_vld_r) begin
        if (cnt_r != '1) cnt_r <= cnt_r + CNT_W'(1);
        ra_sum_r <= ra_add[SCORE_W] ? '1 : ra_add[SCORE_W-1:0];
        aa_sum_r <= aa_add[SCORE_W] ? '1 : aa_add[SCORE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_term_r <= RA_TAB[deg_cap];
    aa_term_r <= AA_TAB[deg_cap];
  end

  assign cnt    = cnt_r;
  assign ra_sum = ra_sum_r;
  assign aa_sum = aa_sum_r;

endmodule

FILE: rtl/link_similarity_scores.sv
// ----------------------------------------------------------------------------
// link_similarity_scores: graph edge updates and link similarity scoring
// Keeps an adjacency bit matrix and a degree table in on-chip memories and
// answers add, remove and score requests, one result per request.
// ----------------------------------------------------------------------------
// After reset the block clears the adjacency memory (one row word per cycle,
// the degree table alongside) with in_tready low. Requests are then handled
// one at a time: an edge add or remove checks the edge bit in S_EDGE, writes
// the first half there and the second half in S_EDGE_WR2 before S_DONE (a
// rejected one goes from S_EDGE straight to S_DONE), and for a score each of
// the four 64-bit row words of both nodes is read in parallel from the two read
// ports of the adjacency memory, and every set bit of their AND costs one
// degree-memory read. A finished result sits in the output register, so the
// next request is taken while the previous result still waits.
// ----------------------------------------------------------------------------
module link_similarity_scores import lsim_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operation[1:0], node_a[9:2], node_b[17:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // status[1:0], common_count[10:2],
                                  // ra_score[42:11], aa_score[74:43]
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE,
    S_EDGE_WR2,
    S_SC_RD,
    S_SC_AND,
    S_SC_SCAN,
    S_DRAIN1,
    S_DRAIN2,
    S_DONE
  } state_t;

  state_t state_r;

  // Memories
  logic [WORD_W-1:0] adj_mem [0:ADJ_DEPTH-1];
  logic [DEG_W-1:0]  deg_mem [0:NODE_COUNT-1];

  // Request fields
  op_t               in_op;
  logic [NODE_W-1:0] in_a;
  logic [NODE_W-1:0] in_b;
  logic              in_fire;
  logic              in_rng;

  // Held request
  op_t               op_r;
  logic [NODE_W-1:0] a_r;
  logic [NODE_W-1:0] b_r;
  logic              score_r;
  status_t           status_r;

  logic [ADJ_AW-1:0] clr_r;
  logic [WSEL_W-1:0] w_r;
  logic [WORD_W-1:0] m_r;
  logic              p1_r;

  // Memory ports
  logic [ADJ_AW-1:0] adj_ra;
  logic [ADJ_AW-1:0] adj_rb;
  logic [WORD_W-1:0] adj_rd_a_r;
  logic [WORD_W-1:0] adj_rd_b_r;
  logic              adj_we;
  logic [ADJ_AW-1:0] adj_wa;
  logic [WORD_W-1:0] adj_wd;
  logic [NODE_W-1:0] deg_ra;
  logic [NODE_W-1:0] deg_rb;
  logic [DEG_W-1:0]  deg_rd_a_r;
  logic [DEG_W-1:0]  deg_rd_b_r;
  logic              deg_we;
  logic [NODE_W-1:0] deg_wa;
  logic [DEG_W-1:0]  deg_wd;

  // Edge check
  logic              edge_bit;
  logic              edge_rng;
  status_t           edge_status;

  // Mask scan
  logic [WORD_W-1:0] m_low;
  logic [BIT_W-1:0]  m_idx;

  // Accumulator
  acc_ctrl_t          acc_ctrl;
  logic [CNT_W-1:0]   acc_cnt;
  logic [SCORE_W-1:0] acc_ra;
  logic [SCORE_W-1:0] acc_aa;

  // Output register
  logic               out_tvalid_r;
  status_t            out_status_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [SCORE_W-1:0] out_ra_r;
  logic [SCORE_W-1:0] out_aa_r;
  logic               out_load;

  // Unpack the request
  assign in_op   = op_t'(in_tdata[1:0]);
  assign in_a    = in_tdata[9:2];
  assign in_b    = in_tdata[17:10];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire = in_tvalid && in_tready;
  assign in_rng  = ({1'b0, in_a} < (NODE_W+1)'(NODE_COUNT)) &&
                   ({1'b0, in_b} < (NODE_W+1)'(NODE_COUNT));

  // Select read addresses
  always_comb begin
    case (state_r)
      S_IDLE: begin
        adj_ra = {in_a, in_b[NODE_W-1:BIT_W]};
        adj_rb = {in_b, in_a[NODE_W-1:BIT_W]};
        deg_ra = in_a;
      end
      S_SC_RD: begin
        adj_ra = {a_r, w_r};
        adj_rb = {b_r, w_r};
        deg_ra = a_r;
      end
      S_SC_SCAN: begin
        adj_ra = {a_r, w_r};
        adj_rb = {b_r, w_r};
        deg_ra = {w_r, m_idx};
      end
      default: begin
        adj_ra = {a_r, b_r[NODE_W-1:BIT_W]};
        adj_rb = {b_r, a_r[NODE_W-1:BIT_W]};
        deg_ra = a_r;
      end
    endcase
    deg_rb = (state_r == S_IDLE) ? in_b : b_r;
  end

  // Check the edge bit against the operation
  assign edge_bit = adj_rd_a_r[b_r[BIT_W-1:0]];
  assign edge_rng = ({1'b0, a_r} < (NODE_W+1)'(NODE_COUNT)) &&
                    ({1'b0, b_r} < (NODE_W+1)'(NODE_COUNT));

  always_comb begin
    if (!edge_rng) begin
      edge_status = ST_ABSENT;
    end else if (a_r == b_r) begin
      edge_status = ST_SAME_NODE;
    end else if (op_r == OP_ADD && edge_bit) begin
      edge_status = ST_PRESENT;
    end else if (op_r == OP_REMOVE && !edge_bit) begin
      edge_status = ST_ABSENT;
    end else begin
      edge_status = ST_OK;
    end
  end

  // Select writes: clearing pass, then the two halves of an edge update
  always_comb begin
    adj_we = 1'b0;
    adj_wa = clr_r;
    adj_wd = '0;
    deg_we = 1'b0;
    deg_wa = clr_r[NODE_W-1:0];
    deg_wd = '0;
    case (state_r)
      S_CLEAR: begin
        adj_we = 1'b1;
        deg_we = 1'b1;
      end
      S_EDGE: begin
        adj_we = (edge_status == ST_OK);
        adj_wa = {a_r, b_r[NODE_W-1:BIT_W]};
        adj_wd = adj_rd_a_r ^ (WORD_W'(1) << b_r[BIT_W-1:0]);
        deg_we = (edge_status == ST_OK);
        deg_wa = a_r;
        deg_wd = (op_r == OP_ADD) ? deg_rd_a_r + DEG_W'(1) : deg_rd_a_r - DEG_W'(1);
      end
      S_EDGE_WR2: begin
        adj_we = 1'b1;
        adj_wa = {b_r, a_r[NODE_W-1:BIT_W]};
        adj_wd = adj_rd_b_r ^ (WORD_W'(1) << a_r[BIT_W-1:0]);
        deg_we = 1'b1;
        deg_wa = b_r;
        deg_wd = (op_r == OP_ADD) ? deg_rd_b_r + DEG_W'(1) : deg_rd_b_r - DEG_W'(1);
      end
      default: begin
        adj_we = 1'b0;
        deg_we = 1'b0;
      end
    endcase
  end

  // Adjacency memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd_a_r <= adj_mem[adj_ra];
    adj_rd_b_r <= adj_mem[adj_rb];
  end

  // Degree memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd_a_r <= deg_mem[deg_ra];
    deg_rd_b_r <= deg_mem[deg_rb];
  end

  // Lowest set bit of the common-neighbor mask
  assign m_low = m_r & (~m_r + WORD_W'(1));

  always_comb begin
    m_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (m_low[i]) m_idx = m_idx | BIT_W'(i);
    end
  end

  // Accumulator control
  assign acc_ctrl.clear     = in_fire && (in_op == OP_SCORE);
  assign acc_ctrl.deg_valid = p1_r;

  lsim_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (acc_ctrl),
    .deg    (deg_rd_a_r),
    .cnt    (acc_cnt),
    .ra_sum (acc_ra),
    .aa_sum (acc_aa)
  );

  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      p1_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      p1_r <= 1'b0;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + ADJ_AW'(1);
          if (clr_r == ADJ_AW'(ADJ_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            op_r     <= in_op;
            a_r      <= in_a;
            b_r      <= in_b;
            w_r      <= '0;
            status_r <= ST_OK;
            score_r  <= (in_op == OP_SCORE) && in_rng;
            if (in_op == OP_ADD || in_op == OP_REMOVE) begin
              state_r <= S_EDGE;
            end else if (in_op == OP_SCORE && in_rng) begin
              state_r <= S_SC_RD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_EDGE: begin
          status_r <= edge_status;
          state_r  <= (edge_status == ST_OK) ? S_EDGE_WR2 : S_DONE;
        end
        S_EDGE_WR2: begin
          state_r <= S_DONE;
        end
        S_SC_RD: begin
          state_r <= S_SC_AND;
        end
        S_SC_AND: begin
          m_r     <= adj_rd_a_r & adj_rd_b_r;
          state_r <= S_SC_SCAN;
        end
        S_SC_SCAN: begin
          if (m_r != '0) begin
            // issue one degree read per common neighbor
            p1_r <= 1'b1;
            m_r  <= m_r ^ m_low;
          end else if (w_r == WSEL_W'(ROW_WORDS - 1)) begin
            state_r <= S_DRAIN1;
          end else begin
            w_r     <= w_r + WSEL_W'(1);
            state_r <= S_SC_RD;
          end
        end
        S_DRAIN1: begin
          state_r <= S_DRAIN2;
        end
        S_DRAIN2: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_status_r <= status_r;
            out_cnt_r    <= score_r ? acc_cnt : '0;
            out_ra_r     <= score_r ? acc_ra : '0;
            out_aa_r     <= score_r ? acc_aa : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_aa_r, out_ra_r, out_cnt_r, out_status_r};

  // The write in S_EDGE_WR2 only follows an accepted write in S_EDGE
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE_WR2) |-> ($past(state_r) == S_EDGE && a_r != b_r))
    else $error("second edge write without a valid first write");

  // The graph is never written while a score is in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SC_RD || state_r == S_SC_AND || state_r == S_SC_SCAN) |-> !adj_we && !deg_we)
    else $error("memory write during a score");

  // Degree data reaches the accumulator only after a scan issue
  assert property (@(posedge clk) disable iff (!rst_n)
    acc_ctrl.deg_valid |-> $past(state_r == S_SC_SCAN))
    else $error("degree valid without a scan read");

  // A held result is not overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_tvalid && !out_tready) |=> (state_r == S_DONE))
    else $error("result register overwritten while stalled");

  // Nothing is accepted while the clearing pass runs
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> !$past(in_fire))
    else $error("request accepted during clearing pass");

endmodule
